>>> hw/rtl/mes_pkg.sv
// Shared types and constants for the music event sequencer.
package mes_pkg;

    localparam int PROGRAM_DEPTH_DEF = 256;
    localparam int MAX_STEPS_DEF     = 31;
    localparam int QUEUE_DEPTH       = 2;

    typedef enum logic [1:0] {
        FUNC_WRITE = 2'd0,
        FUNC_INIT  = 2'd1,
        FUNC_PLAY  = 2'd2
    } t_func;

    typedef enum logic [2:0] {
        OP_NOP    = 3'd0,
        OP_KEYON  = 3'd1,
        OP_KEYOFF = 3'd2,
        OP_WAIT   = 3'd3,
        OP_END    = 3'd4
    } t_opcode;

    typedef enum logic [1:0] {
        KIND_PRESS    = 2'd0,
        KIND_RELEASE  = 2'd1,
        KIND_DONE     = 2'd2,
        KIND_DONE_CUT = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_EXEC
    } t_back_state;

    typedef struct packed {
        logic [7:0]  channel;
        logic [2:0]  opcode;
        logic [31:0] operand;
    } t_instr;

    typedef struct packed {
        t_func       func;
        logic [31:0] time_ms;
        logic [7:0]  slot;
        t_instr      instr;
    } t_cmd;

endpackage

>>> hw/rtl/mes_in_if.sv
// Input item channel of the music event sequencer.
interface mes_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [31:0] time_ms;
    logic [7:0]  wr_index;
    logic [7:0]  wr_channel;
    logic [2:0]  wr_opcode;
    logic [31:0] wr_operand;

    modport source (
        output valid, func, time_ms, wr_index, wr_channel, wr_opcode, wr_operand,
        input  ready
    );
    modport sink (
        input  valid, func, time_ms, wr_index, wr_channel, wr_opcode, wr_operand,
        output ready
    );
endinterface

>>> hw/rtl/mes_out_if.sv
// Result item channel of the music event sequencer.
interface mes_out_if;
    logic          valid;
    logic          ready;
    mes_pkg::t_kind kind;
    logic [7:0]    channel;
    logic [31:0]   note;
    logic          last;

    modport source (
        output valid, kind, channel, note, last,
        input  ready
    );
    modport sink (
        input  valid, kind, channel, note, last,
        output ready
    );
endinterface

>>> hw/rtl/mes_front.sv
// Front end: takes input items, reduces the slot index and forms commands.
module mes_front #(
    parameter int PROGRAM_DEPTH = mes_pkg::PROGRAM_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    mes_in_if.sink        i_in,
    output logic          o_cmd_valid,
    output mes_pkg::t_cmd o_cmd,
    input  logic          i_cmd_ready
);

    logic          r_valid;
    logic          n_valid;
    mes_pkg::t_cmd r_cmd;
    mes_pkg::t_cmd n_cmd;
    logic [7:0]    n_slot;
    logic          take;
    logic          known;

    assign i_in.ready  = !r_valid || i_cmd_ready;
    assign take        = i_in.valid && i_in.ready;
    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

    always_comb begin
        case (i_in.func)
            mes_pkg::FUNC_WRITE, mes_pkg::FUNC_INIT, mes_pkg::FUNC_PLAY: known = 1'b1;
            default: known = 1'b0;
        endcase
    end

    // slot modulo depth by restoring reduction against shifted multiples
    always_comb begin
        n_slot = i_in.wr_index;
        for (int k = 7; k >= 0; k--) begin
            if ((PROGRAM_DEPTH << k) < 256) begin
                if (n_slot >= 8'(PROGRAM_DEPTH << k)) begin
                    n_slot = n_slot - 8'(PROGRAM_DEPTH << k);
                end
            end
        end
    end

    always_comb begin
        n_valid = r_valid && !i_cmd_ready;
        n_cmd   = r_cmd;
        if (take && known) begin
            n_valid               = 1'b1;
            n_cmd.func            = mes_pkg::t_func'(i_in.func);
            n_cmd.time_ms         = i_in.time_ms;
            n_cmd.slot            = n_slot;
            n_cmd.instr.channel   = i_in.wr_channel;
            n_cmd.instr.opcode    = i_in.wr_opcode;
            n_cmd.instr.operand   = i_in.wr_operand;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
    end

endmodule

>>> hw/rtl/mes_queue.sv
// Short command queue between the front end and the execution unit.
module mes_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push_valid,
    input  mes_pkg::t_cmd i_push_cmd,
    output logic          o_push_ready,
    output logic          o_head_valid,
    output mes_pkg::t_cmd o_head_cmd,
    input  logic          i_pop
);

    localparam int QW = (mes_pkg::QUEUE_DEPTH > 1) ? $clog2(mes_pkg::QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(mes_pkg::QUEUE_DEPTH + 1);

    mes_pkg::t_cmd r_q [mes_pkg::QUEUE_DEPTH];
    logic [QW-1:0] r_wr_ptr;
    logic [QW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic [QW-1:0] n_wr_ptr;
    logic [QW-1:0] n_rd_ptr;
    logic [CW-1:0] n_count;
    logic          push;

    assign o_push_ready = (r_count != CW'(mes_pkg::QUEUE_DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head_cmd   = r_q[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == QW'(mes_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == QW'(mes_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= i_push_cmd;
        end
    end

`ifndef NO_ASSERTIONS
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_head_valid)
        else $error("queue popped while empty");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(mes_pkg::QUEUE_DEPTH))
        else $error("queue count out of range");
    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !i_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count missed a push");
`endif

endmodule

>>> hw/rtl/mes_back.sv
// Execution unit: program store, due time, instruction stepping, result register.
module mes_back #(
    parameter int PROGRAM_DEPTH = mes_pkg::PROGRAM_DEPTH_DEF,
    parameter int MAX_STEPS     = mes_pkg::MAX_STEPS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  mes_pkg::t_cmd i_q_cmd,
    output logic          o_q_pop,
    mes_out_if.source     o_out
);

    localparam int AW = $clog2(PROGRAM_DEPTH);
    localparam int SW = $clog2(MAX_STEPS + 1);

    mes_pkg::t_instr      r_mem [PROGRAM_DEPTH];
    mes_pkg::t_instr      r_rdata;
    mes_pkg::t_back_state r_state;
    mes_pkg::t_back_state n_state;
    logic [AW-1:0]        r_idx;
    logic [AW-1:0]        n_idx;
    logic [31:0]          r_due;
    logic [31:0]          n_due;
    logic [SW-1:0]        r_steps;
    logic [SW-1:0]        n_steps;
    logic                 r_out_valid;
    logic                 n_out_valid;
    mes_pkg::t_kind       r_out_kind;
    mes_pkg::t_kind       n_out_kind;
    logic [7:0]           r_out_channel;
    logic [7:0]           n_out_channel;
    logic [31:0]          r_out_note;
    logic [31:0]          n_out_note;
    logic                 r_out_last;
    logic                 n_out_last;
    logic                 mem_we;
    logic                 rd_en;
    logic                 out_take;
    logic                 out_free;
    logic                 due_ok;

    assign o_out.valid   = r_out_valid;
    assign o_out.kind    = r_out_kind;
    assign o_out.channel = r_out_channel;
    assign o_out.note    = r_out_note;
    assign o_out.last    = r_out_last;

    assign out_take = r_out_valid && o_out.ready;
    assign out_free = !r_out_valid || out_take;
    assign due_ok   = (i_q_cmd.time_ms >= r_due);

    always_comb begin
        n_state       = r_state;
        n_idx         = r_idx;
        n_due         = r_due;
        n_steps       = r_steps;
        n_out_valid   = r_out_valid && !out_take;
        n_out_kind    = r_out_kind;
        n_out_channel = r_out_channel;
        n_out_note    = r_out_note;
        n_out_last    = r_out_last;
        o_q_pop       = 1'b0;
        mem_we        = 1'b0;
        rd_en         = 1'b0;
        case (r_state)
            mes_pkg::ST_IDLE: begin
                if (i_q_valid) begin
                    case (i_q_cmd.func)
                        mes_pkg::FUNC_WRITE: begin
                            mem_we  = 1'b1;
                            o_q_pop = 1'b1;
                        end
                        mes_pkg::FUNC_INIT: begin
                            n_idx   = '0;
                            n_due   = i_q_cmd.time_ms;
                            o_q_pop = 1'b1;
                        end
                        mes_pkg::FUNC_PLAY: begin
                            n_steps = '0;
                            n_state = mes_pkg::ST_CHECK;
                        end
                        default: o_q_pop = 1'b1;
                    endcase
                end
            end
            mes_pkg::ST_CHECK: begin
                if (due_ok && (r_steps < SW'(MAX_STEPS))) begin
                    rd_en   = 1'b1;
                    n_idx   = (r_idx == AW'(PROGRAM_DEPTH - 1)) ? '0 : r_idx + 1'b1;
                    n_steps = r_steps + 1'b1;
                    n_state = mes_pkg::ST_EXEC;
                end else if (out_free) begin
                    n_out_valid   = 1'b1;
                    n_out_kind    = due_ok ? mes_pkg::KIND_DONE_CUT : mes_pkg::KIND_DONE;
                    n_out_channel = '0;
                    n_out_note    = '0;
                    n_out_last    = 1'b1;
                    o_q_pop       = 1'b1;
                    n_state       = mes_pkg::ST_IDLE;
                end
            end
            mes_pkg::ST_EXEC: begin
                case (r_rdata.opcode)
                    mes_pkg::OP_KEYON: begin
                        if (out_free) begin
                            n_out_valid   = 1'b1;
                            n_out_kind    = mes_pkg::KIND_PRESS;
                            n_out_channel = r_rdata.channel;
                            n_out_note    = r_rdata.operand;
                            n_out_last    = 1'b0;
                            n_state       = mes_pkg::ST_CHECK;
                        end
                    end
                    mes_pkg::OP_KEYOFF: begin
                        if (out_free) begin
                            n_out_valid   = 1'b1;
                            n_out_kind    = mes_pkg::KIND_RELEASE;
                            n_out_channel = r_rdata.channel;
                            n_out_note    = '0;
                            n_out_last    = 1'b0;
                            n_state       = mes_pkg::ST_CHECK;
                        end
                    end
                    mes_pkg::OP_WAIT: begin
                        n_due   = r_due + r_rdata.operand;
                        n_state = mes_pkg::ST_CHECK;
                    end
                    mes_pkg::OP_END: begin
                        n_idx   = '0;
                        n_state = mes_pkg::ST_CHECK;
                    end
                    default: n_state = mes_pkg::ST_CHECK;
                endcase
            end
            default: n_state = mes_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mes_pkg::ST_IDLE;
            r_idx       <= '0;
            r_due       <= '0;
            r_steps     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_due       <= n_due;
            r_steps     <= n_steps;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_kind    <= n_out_kind;
        r_out_channel <= n_out_channel;
        r_out_note    <= n_out_note;
        r_out_last    <= n_out_last;
    end

    // program store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[AW'(i_q_cmd.slot)] <= i_q_cmd.instr;
        end
        if (rd_en) begin
            r_rdata <= r_mem[r_idx];
        end
    end

`ifndef NO_ASSERTIONS
    a_step_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_steps <= SW'(MAX_STEPS))
        else $error("step count past cap");
    a_exec_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mes_pkg::ST_EXEC && $past(r_state) != mes_pkg::ST_EXEC) |-> $past(rd_en))
        else $error("execute without store read");
    a_pop_has_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> i_q_valid)
        else $error("pop without queued command");
    a_play_ends_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mes_pkg::ST_CHECK && n_state == mes_pkg::ST_IDLE) |=>
            (r_out_valid && r_out_last))
        else $error("play finished without done result");
`endif

endmodule

>>> hw/rtl/music_event_sequencer_core.sv
// Music event sequencer: program store stepped against a millisecond clock.
//
// Input channel i_in (valid/ready): func 0 stores an instruction at
// wr_index (modulo the store depth), func 1 rewinds the program and loads
// the due time, func 2 plays at time_ms; func 3 is taken and dropped.
// Output channel o_out (valid/ready): key press and release items, then one
// done item (last = 1, kind 3 when the step cap cut the play short).
// Write and init items produce no output.
// An accepted item passes through the front register and then the command
// queue. The execution unit handles write and init items in its idle state;
// a play item moves to the check state, runs each instruction as a store
// read and then an execute step, and ends with the done item, running at
// most MAX_STEPS instructions. The store read port is registered.
// The front keeps accepting until the queue and its register are full.
// A stalled receiver holds the execution unit at the next key event or done
// item; nothing is dropped. Reset clears the program index, the due time,
// the queue and all valid flags; store contents are kept but undefined.
module music_event_sequencer_core #(
    parameter int PROGRAM_DEPTH = mes_pkg::PROGRAM_DEPTH_DEF,
    parameter int MAX_STEPS     = mes_pkg::MAX_STEPS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mes_in_if.sink    i_in,
    mes_out_if.source o_out
);

    logic          cmd_valid;
    logic          cmd_ready;
    mes_pkg::t_cmd cmd;
    logic          head_valid;
    mes_pkg::t_cmd head_cmd;
    logic          head_pop;

    mes_front #(
        .PROGRAM_DEPTH (PROGRAM_DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_ready (cmd_ready)
    );

    mes_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (cmd_valid),
        .i_push_cmd   (cmd),
        .o_push_ready (cmd_ready),
        .o_head_valid (head_valid),
        .o_head_cmd   (head_cmd),
        .i_pop        (head_pop)
    );

    mes_back #(
        .PROGRAM_DEPTH (PROGRAM_DEPTH),
        .MAX_STEPS     (MAX_STEPS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (head_valid),
        .i_q_cmd   (head_cmd),
        .o_q_pop   (head_pop),
        .o_out     (o_out)
    );

endmodule

>>> tb/sv/mes_checker.sv
// Scoreboard for the music event sequencer: predicts key events and done items, compares them.
`timescale 1ns / 1ps
module mes_checker #(
    parameter int PROGRAM_DEPTH = mes_pkg::PROGRAM_DEPTH_DEF,
    parameter int MAX_STEPS     = mes_pkg::MAX_STEPS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    mes_in_if    i_in,
    mes_out_if   i_out,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_events_seen,
    output int   o_cut_plays
);

    localparam int MAX_REPORTS = 40;

    typedef struct {
        mes_pkg::t_kind kind;
        logic [7:0]     channel;
        logic [31:0]    note;
        logic           last;
    } t_sound_event;

    logic [7:0]   slot_chan [PROGRAM_DEPTH];
    logic [2:0]   slot_op   [PROGRAM_DEPTH];
    logic [31:0]  slot_arg  [PROGRAM_DEPTH];
    logic [31:0]  due_ms;
    int           prog_idx;
    t_sound_event awaited_events[$];

    task automatic report(input string msg);
        if (o_fail_count < MAX_REPORTS)
            $display("[%0t] mismatch: %s", $time, msg);
        o_fail_count++;
    endtask

    function automatic t_sound_event make_event(input mes_pkg::t_kind kind,
                                                input logic [7:0] chan,
                                                input logic [31:0] note, input logic last);
        t_sound_event ev;
        ev.kind    = kind;
        ev.channel = chan;
        ev.note    = note;
        ev.last    = last;
        return ev;
    endfunction

    // One play item: step through the program while the due time has been reached, at most MAX_STEPS steps.
    task automatic run_program(input logic [31:0] now);
        int         steps;
        int         slot;
        logic [2:0] op;
        steps = 0;
        while (now >= due_ms && steps < MAX_STEPS) begin
            slot     = prog_idx;
            op       = slot_op[slot];
            prog_idx = (slot + 1) % PROGRAM_DEPTH;
            steps++;
            case (op)
                mes_pkg::OP_KEYON:  awaited_events.push_back(
                               make_event(mes_pkg::KIND_PRESS, slot_chan[slot], slot_arg[slot],
                                          1'b0));
                mes_pkg::OP_KEYOFF: awaited_events.push_back(
                               make_event(mes_pkg::KIND_RELEASE, slot_chan[slot], '0, 1'b0));
                mes_pkg::OP_WAIT:   due_ms = due_ms + slot_arg[slot];
                mes_pkg::OP_END:    prog_idx = 0;
                default:   ;
            endcase
        end
        if (now >= due_ms) begin
            awaited_events.push_back(make_event(mes_pkg::KIND_DONE_CUT, '0, '0, 1'b1));
            o_cut_plays++;
        end else begin
            awaited_events.push_back(make_event(mes_pkg::KIND_DONE, '0, '0, 1'b1));
        end
    endtask

    always @(posedge i_clk) begin
        t_sound_event want;
        int           slot;
        if (!i_rst_n) begin
            due_ms   = '0;
            prog_idx = 0;
            awaited_events.delete();
        end else begin
            // results first: an item accepted on this edge cannot have produced one yet
            if (i_out.valid && i_out.ready) begin
                o_events_seen++;
                if (awaited_events.size() == 0) begin
                    report($sformatf("result item with nothing awaited (kind %0d)", i_out.kind));
                end else begin
                    want = awaited_events.pop_front();
                    if (i_out.kind !== want.kind)
                        report($sformatf("kind: expected %0d, got %0d", want.kind, i_out.kind));
                    if (i_out.channel !== want.channel)
                        report($sformatf("channel: expected 0x%0h, got 0x%0h",
                                         want.channel, i_out.channel));
                    if (i_out.note !== want.note)
                        report($sformatf("note: expected 0x%0h, got 0x%0h", want.note, i_out.note));
                    if (i_out.last !== want.last)
                        report($sformatf("last: expected %0b, got %0b", want.last, i_out.last));
                end
            end
            if (i_in.valid && i_in.ready) begin
                case (i_in.func)
                    mes_pkg::FUNC_WRITE: begin
                        slot            = i_in.wr_index % PROGRAM_DEPTH;
                        slot_chan[slot] = i_in.wr_channel;
                        slot_op[slot]   = i_in.wr_opcode;
                        slot_arg[slot]  = i_in.wr_operand;
                    end
                    mes_pkg::FUNC_INIT: begin
                        prog_idx = 0;
                        due_ms   = i_in.time_ms;
                    end
                    mes_pkg::FUNC_PLAY: run_program(i_in.time_ms);
                    default:   ;
                endcase
            end
        end
        o_pending = awaited_events.size();
    end

endmodule

>>> tb/sv/music_event_sequencer_core_tb.sv
// Testbench top for the music event sequencer: clock, reset, stimulus, back-pressure and verdict.
`timescale 1ns / 1ps
module music_event_sequencer_core_tb;

    localparam logic [1:0] FUNC_UNUSED   = 2'd3;
    localparam logic [2:0] OP_SPARE_LO   = 3'd5;
    localparam logic [2:0] OP_SPARE_HI   = 3'd7;
    localparam int         STORE_SLOTS   = mes_pkg::PROGRAM_DEPTH_DEF;
    localparam int         PHASE_A_ITEMS = 100;
    localparam int         PHASE_B_ITEMS = 110;
    localparam int         QUIET_TAIL    = 60;
    localparam int         DRAIN_CYCLES  = 100;
    localparam int         CYCLE_LIMIT   = 1_200_000;

    logic        i_clk;
    logic        i_rst_n;
    int          fail_count;
    int          pending;
    int          events_seen;
    int          cut_plays;
    int          cycle_cnt;
    bit          idle_on;
    int          prog_len;     // slots 0..prog_len-1 are written; the last is an end unless full
    logic [31:0] now_ms;
    int          n_writes;
    int          n_inits;
    int          n_plays;
    int          n_spare;

    mes_in_if  in_ch ();
    mes_out_if out_ch ();

    music_event_sequencer_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    mes_checker chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (in_ch),
        .i_out         (out_ch),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_events_seen (events_seen),
        .o_cut_plays   (cut_plays)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // receiver back-pressure in bursts
    initial begin
        int stall_left;
        stall_left   = 0;
        out_ch.ready = 1'b1;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                out_ch.ready = 1'b0;
                stall_left--;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                out_ch.ready = 1'b0;
                stall_left   = $urandom_range(0, 11);
            end else begin
                out_ch.ready = 1'b1;
            end
        end
    end

    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("timeout after %0d cycles with %0d results awaited", cycle_cnt, pending);
        $display("FAILED: results differ");
        $finish;
    end

    function automatic int items_done();
        return n_writes + n_inits + n_plays;
    endfunction

    task automatic push_item(input logic [1:0] func, input logic [31:0] t_ms,
                             input logic [7:0] idx, input logic [7:0] chan,
                             input logic [2:0] op, input logic [31:0] arg);
        int gap;
        gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid      = 1'b1;
        in_ch.func       = func;
        in_ch.time_ms    = t_ms;
        in_ch.wr_index   = idx;
        in_ch.wr_channel = chan;
        in_ch.wr_opcode  = op;
        in_ch.wr_operand = arg;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    task automatic write_slot(input logic [7:0] idx, input logic [7:0] chan,
                              input logic [2:0] op, input logic [31:0] arg);
        push_item(mes_pkg::FUNC_WRITE, $urandom, idx, chan, op, arg);
        n_writes++;
        if (int'(idx) == prog_len)
            prog_len++;
    endtask

    task automatic start_at(input logic [31:0] t_ms);
        push_item(mes_pkg::FUNC_INIT, t_ms, 8'($urandom), 8'($urandom), 3'($urandom), $urandom);
        n_inits++;
    endtask

    task automatic play_at(input logic [31:0] t_ms);
        push_item(mes_pkg::FUNC_PLAY, t_ms, 8'($urandom), 8'($urandom), 3'($urandom), $urandom);
        n_plays++;
    endtask

    task automatic send_spare();
        push_item(FUNC_UNUSED, $urandom, 8'($urandom), 8'($urandom), 3'($urandom), $urandom);
        n_spare++;
    endtask

    function automatic logic [2:0] rand_op();
        int r;
        r = $urandom_range(0, 19);
        if (r < 6)       return mes_pkg::OP_KEYON;
        else if (r < 11) return mes_pkg::OP_KEYOFF;
        else if (r < 13) return mes_pkg::OP_NOP;
        else if (r < 16) return mes_pkg::OP_WAIT;
        else if (r < 17) return mes_pkg::OP_END;
        else             return 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
    endfunction

    // waits are mostly short so plays keep making progress; a few are huge or zero
    function automatic logic [31:0] rand_arg(input logic [2:0] op);
        int r;
        r = $urandom_range(0, 15);
        if (r == 0)      return '0;
        else if (r == 1) return '1;
        else if (op == mes_pkg::OP_WAIT && r > 2) return $urandom_range(1, 25);
        else             return $urandom;
    endfunction

    function automatic logic [31:0] next_play_time();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)      return $urandom;
        else if (r == 1) return '1;
        now_ms = now_ms + $urandom_range(0, 12);
        return now_ms;
    endfunction

    // Execution never leaves the written prefix: only the tail slot may close it,
    // and that slot changes only by appending a new end behind it.
    task automatic rand_write();
        logic [7:0] idx;
        logic [2:0] op;
        if (prog_len >= STORE_SLOTS) begin
            idx = 8'($urandom);
            op  = rand_op();
        end else if (prog_len < 2 || $urandom_range(0, 1) == 0) begin
            idx = 8'(prog_len);
            op  = mes_pkg::OP_END;
        end else begin
            idx = 8'($urandom_range(0, prog_len - 2));
            op  = rand_op();
        end
        write_slot(idx, 8'($urandom), op, rand_arg(op));
    endtask

    task automatic rand_item();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35) begin
            rand_write();
        end else if (r < 45) begin
            case ($urandom_range(0, 3))
                0:       now_ms = $urandom;
                1:       now_ms = 32'hFFFF_FFF0;
                default: ;
            endcase
            start_at(now_ms);
        end else if (r < 96) begin
            play_at(next_play_time());
        end else begin
            send_spare();
        end
    endtask

    initial begin
        int         base;
        logic [2:0] op;
        i_rst_n          = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.func       = mes_pkg::FUNC_WRITE;
        in_ch.time_ms    = '0;
        in_ch.wr_index   = '0;
        in_ch.wr_channel = '0;
        in_ch.wr_opcode  = mes_pkg::OP_NOP;
        in_ch.wr_operand = '0;
        idle_on          = 1'b1;
        prog_len         = 0;
        now_ms           = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // short program with every opcode, field extremes and a wrapping wait
        write_slot(8'd0, 8'hFF, mes_pkg::OP_KEYON, 32'hFFFF_FFFF);
        write_slot(8'd1, 8'h00, mes_pkg::OP_KEYOFF, 32'h0);
        write_slot(8'd2, 8'hAA, mes_pkg::OP_NOP, 32'h5555_5555);
        write_slot(8'd3, 8'h55, OP_SPARE_HI, 32'hAAAA_AAAA);
        write_slot(8'd4, 8'h0F, mes_pkg::OP_WAIT, 32'd10);
        write_slot(8'd5, 8'h5A, mes_pkg::OP_KEYON, 32'h0);
        write_slot(8'd6, 8'hF0, mes_pkg::OP_WAIT, 32'hFFFF_FFFF);
        write_slot(8'd7, 8'h3C, mes_pkg::OP_END, 32'h1234_5678);
        start_at(32'd100);
        play_at(32'd99);                 // not yet due
        play_at(32'd100);                // runs up to the first wait
        play_at(32'd110);                // wait of all ones steps due back, then rewinds
        play_at(32'hFFFF_FFFF);          // hits the step cap
        play_at(32'hFFFF_FFFF);          // resumes after the cap
        send_spare();
        start_at(32'hFFFF_FFF8);
        play_at(32'hFFFF_FFFF);          // due time wraps past zero
        play_at(32'd0);
        start_at(32'd0);
        play_at(32'd0);

        base = items_done();
        while (items_done() < base + PHASE_A_ITEMS) rand_item();

        // fill the rest of the store so every slot and the index wrap can be reached
        idle_on = 1'b0;
        while (prog_len < STORE_SLOTS) begin
            op = rand_op();
            write_slot(8'(prog_len), 8'($urandom), op, rand_arg(op));
        end
        idle_on = 1'b1;

        base = items_done();
        while (items_done() < base + PHASE_B_ITEMS - QUIET_TAIL) rand_item();
        idle_on = 1'b0;
        while (items_done() < base + PHASE_B_ITEMS) rand_item();

        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Run covered %0d writes, %0d inits, %0d plays and %0d ignored items",
                 n_writes, n_inits, n_plays, n_spare);
        $display("%0d result items checked, %0d plays cut at the step cap, %0d mismatches",
                 events_seen, cut_plays, fail_count);
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/mes_pkg.sv
hw/rtl/mes_in_if.sv
hw/rtl/mes_out_if.sv
hw/rtl/mes_front.sv
hw/rtl/mes_queue.sv
hw/rtl/mes_back.sv
hw/rtl/music_event_sequencer_core.sv
tb/sv/mes_checker.sv
tb/sv/music_event_sequencer_core_tb.sv
